// File: sv/tdsb_pkg.sv
package tdsb_pkg;

  localparam logic [2:0] FN_CHAR  = 3'd0;
  localparam logic [2:0] FN_HEX   = 3'd1;
  localparam logic [2:0] FN_DEC   = 3'd2;
  localparam logic [2:0] FN_CLEAR = 3'd3;
  localparam logic [2:0] FN_FLUSH = 3'd4;

  localparam logic [1:0] CMD_CURSOR = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_DONE   = 2'd2;

  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_ALPHA = 16'h0041;
  localparam logic [7:0]  POS_NONE = 8'hFF;
  localparam int          MAX_DIGITS = 6;

  typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHAR, S_HEX, S_CLR, S_DSTART, S_DWAIT, S_DSIGN,
    S_DLOOP, S_DSUF, S_FRD, S_FCMP, S_FCUR, S_FCHR, S_FDONE
  } state_t;

  function automatic logic [15:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_digit = CH_ZERO + 16'(nib);
    end else begin
      hex_digit = CH_ALPHA + 16'(nib) - 16'd10;
    end
  endfunction

endpackage

// File: sv/tdsb_in_if.sv
interface tdsb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [7:0]         column;
  logic [7:0]         row;
  logic [15:0]        char_code;
  logic [7:0]         hex_data;
  logic signed [31:0] number;
  logic [2:0]         digit_count;
  logic [7:0]         suffix;
  logic               keep_zeros;

  modport source (output valid, func, column, row, char_code, hex_data, number,
                  digit_count, suffix, keep_zeros, input ready);
  modport sink (input valid, func, column, row, char_code, hex_data, number,
                digit_count, suffix, keep_zeros, output ready);
endinterface

// File: sv/tdsb_out_if.sv
interface tdsb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  cursor_column;
  logic [7:0]  cursor_row;
  logic [15:0] out_char;
  logic        last;

  modport source (output valid, command, cursor_column, cursor_row, out_char, last,
                  input ready);
  modport sink (input valid, command, cursor_column, cursor_row, out_char, last,
                output ready);
endinterface

// File: sv/tdsb_ram.sv
module tdsb_ram #(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);
  logic [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/tdsb_digits.sv
module tdsb_digits (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      mag,
  output logic             done,
  output tdsb_pkg::digits_t digits
);
  import tdsb_pkg::*;

  logic        busy_r;
  logic        ph_r;
  logic [2:0]  k_r;
  logic [31:0] mag_r;
  logic [31:0] q_r;
  logic [63:0] prod;
  logic [31:0] rem;
  digits_t     dig_r;

  // divide by 10 through the reciprocal; exact over 32 bits
  assign prod = {32'b0, mag_r} * 64'h00000000CCCCCCCD;
  assign rem  = mag_r - ((q_r << 3) + (q_r << 1));
  assign done = !busy_r;
  assign digits = dig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      k_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      ph_r   <= 1'b0;
      k_r    <= '0;
    end else if (busy_r) begin
      ph_r <= !ph_r;
      if (ph_r) begin
        k_r <= k_r + 3'd1;
        if (k_r == 3'(MAX_DIGITS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
    end else if (busy_r) begin
      if (!ph_r) begin
        q_r <= 32'(prod[63:35]);
      end else begin
        dig_r[k_r] <= rem[3:0];
        mag_r      <= q_r;
      end
    end
  end
endmodule

// File: sv/text_display_shadow_buffer_core.sv
// A decimal field first runs 6 divide-by-10 steps, then writes one cell per cycle.
// One request at a time; a new request is taken once the previous one is done.
// Reset (sync, active low) starts a clearing pass that fills cache and mirror with
// spaces; no request is taken during it.
module text_display_shadow_buffer_core #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 8
) (
  input  logic clk,
  input  logic rst_n,
  tdsb_in_if.sink    in_ch,
  tdsb_out_if.source out_ch
);
  import tdsb_pkg::*;

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW = RW + CW;

  state_t state_r, state_nxt;

  logic [7:0]  col_r, row_r, hex_r, suf_r;
  logic [15:0] code_r;
  logic [31:0] num_r;
  logic [2:0]  cnt_r;
  logic        keep_r;

  logic [AW-1:0] init_r;
  logic [CW-1:0] cidx_r, cidx_nxt;
  logic          hx_r, hx_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [2:0]    j_r, j_nxt;
  logic          started_r, started_nxt, signp_r, signp_nxt;
  logic [ROWS-1:0] dirty_r;
  logic [7:0]    curc_r, curc_nxt, curr_r, curr_nxt;

  logic        out_valid_r;
  logic [1:0]  out_cmd_r;
  logic [7:0]  out_col_r, out_row_r;
  logic [15:0] out_char_r;
  logic        out_last_r;

  logic        accept, row_ok, can_push, at_end, diff, cur_hit, neg, init_end;
  logic [31:0] mag;
  logic [2:0]  nm1;
  logic [3:0]  d;
  logic        show;
  logic        dig_start, dig_done;
  digits_t     digits;
  logic [15:0] cache_q, mirror_q;

  logic        wr_req, wr_en, push, mir_we, dirty_clr;
  logic [8:0]  wr_col;
  logic [15:0] wr_val;
  logic [1:0]  push_cmd;
  logic [7:0]  push_col, push_row;
  logic [15:0] push_char;
  logic        push_last;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign row_ok   = row_r < 8'(ROWS);
  assign can_push = !out_valid_r || out_ch.ready;
  assign at_end   = cidx_r == CW'(COLUMNS - 1);
  assign diff     = cache_q != mirror_q;
  assign cur_hit  = (curc_r == 8'(cidx_r)) && (curr_r == row_r);
  assign neg      = num_r[31];
  assign mag      = neg ? (32'd0 - num_r) : num_r;
  assign init_end = &init_r;
  assign nm1      = neg ? ((cnt_r <= 3'd1) ? 3'd0 : cnt_r - 3'd2)
                        : ((cnt_r == 3'd0) ? 3'd0 : cnt_r - 3'd1);
  assign d        = digits[j_r];
  assign show     = (d != 4'd0) || started_r || (j_r == 3'd0);
  assign dig_start = (state_r == S_DSTART);
  assign wr_en    = wr_req && row_ok && (wr_col < 9'(COLUMNS));

  tdsb_digits u_digits (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dig_start),
    .mag    (mag),
    .done   (dig_done),
    .digits (digits)
  );

  tdsb_ram #(.AW(AW)) u_cache (
    .clk   (clk),
    .we    (wr_en || state_r == S_INIT),
    .waddr (state_r == S_INIT ? init_r : {row_r[RW-1:0], wr_col[CW-1:0]}),
    .wdata (state_r == S_INIT ? CH_SPACE : wr_val),
    .raddr ({row_r[RW-1:0], cidx_r}),
    .rdata (cache_q)
  );

  tdsb_ram #(.AW(AW)) u_mirror (
    .clk   (clk),
    .we    (mir_we || state_r == S_INIT),
    .waddr (state_r == S_INIT ? init_r : {row_r[RW-1:0], cidx_r}),
    .wdata (state_r == S_INIT ? CH_SPACE : cache_q),
    .raddr ({row_r[RW-1:0], cidx_r}),
    .rdata (mirror_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (init_end) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            FN_CHAR:  state_nxt = S_CHAR;
            FN_HEX:   state_nxt = S_HEX;
            FN_DEC:   state_nxt = S_DSTART;
            FN_CLEAR: state_nxt = S_CLR;
            FN_FLUSH: state_nxt = S_FRD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHAR: state_nxt = S_IDLE;
      S_HEX: if (hx_r) state_nxt = S_IDLE;
      S_CLR: if (at_end || !row_ok) state_nxt = S_IDLE;
      S_DSTART: begin
        if (!row_ok || cnt_r > 3'(MAX_DIGITS)) state_nxt = S_IDLE;
        else state_nxt = S_DWAIT;
      end
      S_DWAIT: if (dig_done) state_nxt = neg ? S_DSIGN : S_DLOOP;
      S_DSIGN: state_nxt = S_DLOOP;
      S_DLOOP: begin
        if (pos_r >= 8'(COLUMNS)) state_nxt = S_DSUF;
        else if (!(show && signp_r && (d != 4'd0 || keep_r)) && j_r == 3'd0)
          state_nxt = S_DSUF;
      end
      S_DSUF: state_nxt = S_IDLE;
      S_FRD: begin
        if (!row_ok || !dirty_r[row_r[RW-1:0]]) state_nxt = S_FDONE;
        else state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (diff) state_nxt = cur_hit ? S_FCHR : S_FCUR;
        else state_nxt = at_end ? S_FDONE : S_FRD;
      end
      S_FCUR: if (can_push) state_nxt = S_FCHR;
      S_FCHR: if (can_push) state_nxt = at_end ? S_FDONE : S_FRD;
      S_FDONE: if (can_push) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    wr_req = 1'b0;
    wr_col = {1'b0, col_r};
    wr_val = CH_SPACE;
    push = 1'b0;
    push_cmd = CMD_DONE;
    push_col = '0;
    push_row = '0;
    push_char = '0;
    push_last = 1'b0;
    mir_we = 1'b0;
    dirty_clr = 1'b0;
    cidx_nxt = cidx_r;
    hx_nxt = hx_r;
    pos_nxt = pos_r;
    j_nxt = j_r;
    started_nxt = started_r;
    signp_nxt = signp_r;
    curc_nxt = curc_r;
    curr_nxt = curr_r;
    case (state_r)
      S_IDLE: begin
        cidx_nxt = '0;
        hx_nxt = 1'b0;
      end
      S_CHAR: begin
        wr_req = code_r != 16'd0;
        wr_val = code_r;
      end
      S_HEX: begin
        wr_req = 1'b1;
        wr_col = {1'b0, col_r} + 9'(hx_r);
        wr_val = hx_r ? hex_digit(hex_r[3:0]) : hex_digit(hex_r[7:4]);
        hx_nxt = 1'b1;
      end
      S_CLR: begin
        wr_req = 1'b1;
        wr_col = 9'(cidx_r);
        cidx_nxt = cidx_r + CW'(1);
      end
      S_DSTART: begin
        pos_nxt = col_r;
        j_nxt = nm1;
        started_nxt = keep_r;
        signp_nxt = neg;
      end
      S_DSIGN: begin
        if (pos_r < 8'(COLUMNS)) begin
          wr_req = 1'b1;
          wr_col = {1'b0, pos_r};
          pos_nxt = pos_r + 8'd1;
        end
      end
      S_DLOOP: begin
        if (pos_r < 8'(COLUMNS)) begin
          wr_req = 1'b1;
          if (show && signp_r && (d != 4'd0 || keep_r)) begin
            // sign goes just before the first shown digit; digit follows next cycle
            wr_col = {1'b0, pos_r} - 9'd1;
            wr_val = CH_MINUS;
            signp_nxt = 1'b0;
          end else begin
            wr_col = {1'b0, pos_r};
            wr_val = show ? CH_ZERO + 16'(d) : CH_SPACE;
            if (d != 4'd0) started_nxt = 1'b1;
            pos_nxt = pos_r + 8'd1;
            if (j_r != 3'd0) j_nxt = j_r - 3'd1;
          end
        end
      end
      S_DSUF: begin
        wr_req = (suf_r != 8'd0) && (pos_r < 8'(COLUMNS));
        wr_col = {1'b0, pos_r};
        wr_val = {8'd0, suf_r};
      end
      S_FCMP: begin
        if (!diff) begin
          if (at_end) dirty_clr = 1'b1;
          else cidx_nxt = cidx_r + CW'(1);
        end
      end
      S_FCUR: begin
        if (can_push) begin
          push = 1'b1;
          push_cmd = CMD_CURSOR;
          push_col = 8'(cidx_r);
          push_row = row_r;
          curc_nxt = 8'(cidx_r);
          curr_nxt = row_r;
        end
      end
      S_FCHR: begin
        if (can_push) begin
          push = 1'b1;
          push_cmd = CMD_WRITE;
          push_char = cache_q;
          mir_we = 1'b1;
          curc_nxt = curc_r + 8'd1;
          if (at_end) dirty_clr = 1'b1;
          else cidx_nxt = cidx_r + CW'(1);
        end
      end
      S_FDONE: begin
        if (can_push) begin
          push = 1'b1;
          push_cmd = CMD_DONE;
          push_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r <= '0;
      dirty_r <= '1;
      curc_r <= POS_NONE;
      curr_r <= POS_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) init_r <= init_r + AW'(1);
      if (wr_en) dirty_r[row_r[RW-1:0]] <= 1'b1;
      if (dirty_clr) dirty_r[row_r[RW-1:0]] <= 1'b0;
      curc_r <= curc_nxt;
      curr_r <= curr_nxt;
      if (push) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= in_ch.column;
      row_r  <= in_ch.row;
      code_r <= in_ch.char_code;
      hex_r  <= in_ch.hex_data;
      num_r  <= in_ch.number;
      cnt_r  <= in_ch.digit_count;
      suf_r  <= in_ch.suffix;
      keep_r <= in_ch.keep_zeros;
    end
    cidx_r <= cidx_nxt;
    hx_r <= hx_nxt;
    pos_r <= pos_nxt;
    j_r <= j_nxt;
    started_r <= started_nxt;
    signp_r <= signp_nxt;
    if (push) begin
      out_cmd_r  <= push_cmd;
      out_col_r  <= push_col;
      out_row_r  <= push_row;
      out_char_r <= push_char;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.command       = out_cmd_r;
  assign out_ch.cursor_column = out_col_r;
  assign out_ch.cursor_row    = out_row_r;
  assign out_ch.out_char      = out_char_r;
  assign out_ch.last          = out_last_r;
endmodule
